// ===== hdl/rbmcu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbmcu_pkg: shared types, constants and sigmoid table
// Command codes, controller states, datapath command and status structs, and
// the Q0.16 sigmoid table built at elaboration time.
// ----------------------------------------------------------------------------
package rbmcu_pkg;

  // Store sizes (visible and hidden fixed by the 6-bit row and column fields)
  localparam int VIS_MAX         = 64;
  localparam int HID_MAX         = 64;
  localparam int COND_MAX        = 16;
  localparam int IDX_W           = 6;
  localparam int COND_AW         = 4;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int SIG_AW          = 8;
  localparam int ACC_W           = 40;

  // Configuration register indexes
  localparam logic [1:0] CFG_VIS_COUNT  = 2'd0;
  localparam logic [1:0] CFG_HID_COUNT  = 2'd1;
  localparam logic [1:0] CFG_COND_COUNT = 2'd2;

  typedef enum logic [3:0] {
    CMD_VH_WEIGHT = 4'd0,
    CMD_VIS_BIAS  = 4'd1,
    CMD_HID_BIAS  = 4'd2,
    CMD_CH_WEIGHT = 4'd3,
    CMD_VIS_NODE  = 4'd4,
    CMD_HID_NODE  = 4'd5,
    CMD_COND_NODE = 4'd6,
    CMD_QUERY_HID = 4'd7,
    CMD_QUERY_VIS = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_VHSUM,
    ST_CSUM,
    ST_DRAIN,
    ST_SAT,
    ST_EMIT
  } state_t;

  // Term source of one multiply-accumulate step
  typedef enum logic [2:0] {
    SRC_VBIAS,
    SRC_HBIAS,
    SRC_VH_ROW,
    SRC_VH_COL,
    SRC_COND
  } src_t;

  typedef struct packed {
    logic             wr_en;
    logic             load_item;
    logic             issue;
    src_t             src;
    logic             first;
    logic [IDX_W-1:0] idx;
    logic             sat_en;
    logic             emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef logic [15:0] sig_table_t [SIGMOID_ENTRIES];

  // Restoring shift-subtract division, elaboration use only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-mag, mag and result in Q32
  function automatic logic [63:0] exp_neg_q32(logic [63:0] mag);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] e;
    n    = mag >> 32;
    f    = {32'd0, mag[31:0]};
    term = 64'h1_0000_0000;
    sum  = 64'sh1_0000_0000;
    for (int k = 1; k <= 15; k++) begin
      term = udiv64((term * f) >> 32, 64'(k));
      if ((k % 2) == 1) sum = sum - $signed(term);
      else              sum = sum + $signed(term);
    end
    e = (sum < 0) ? 64'd0 : 64'(sum);
    for (int j = 0; j < 8; j++) begin
      if (64'(j) < n) e = (e * 64'd1580030169 + 64'h8000_0000) >> 32;
    end
    return e;
  endfunction

  // Sigmoid at each bin midpoint, Q0.16, saturated
  function automatic sig_table_t sig_table_build();
    sig_table_t t;
    logic signed [63:0] x;
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] p;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      x   = $signed(udiv64(64'(2 * k + 1) * 64'h8_0000_0000, 64'(SIGMOID_ENTRIES)))
            - 64'sh8_0000_0000;
      mag = (x < 0) ? 64'(-x) : 64'(x);
      e   = exp_neg_q32(mag);
      den = 64'h1_0000_0000 + e;
      if (x >= 0) p = udiv64(64'h1_0000_0000_0000 + (den >> 1), den);
      else        p = udiv64((e << 16) + (den >> 1), den);
      t[k] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = sig_table_build();

endpackage
`default_nettype wire

// ===== hdl/rbmcu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbmcu_ctrl: sequencer for item intake and query accumulation
// Holds the count registers, accepts items, and walks the bias, weighted
// visible or hidden terms and conditional terms through the datapath MAC.
// ----------------------------------------------------------------------------
module rbmcu_ctrl
  import rbmcu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_wdata,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [3:0] in_cmd,
  output dp_cmd_t         dp_cmd,
  input  wire dp_status_t dp_status
);

  state_t      state_r, state_nxt;
  logic [6:0]  vis_count_r, hid_count_r;
  logic [4:0]  cond_count_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        drain_r, drain_nxt;
  logic        is_vis_r, is_vis_nxt;
  logic [6:0]  n_vis, n_hid, n_sum;
  logic [4:0]  n_cond;
  logic        accept, is_query;

  // Clamped term counts
  assign n_vis  = (vis_count_r > 7'(VIS_MAX)) ? 7'(VIS_MAX) : vis_count_r;
  assign n_hid  = (hid_count_r > 7'(HID_MAX)) ? 7'(HID_MAX) : hid_count_r;
  assign n_cond = (cond_count_r > 5'(COND_MAX)) ? 5'(COND_MAX) : cond_count_r;
  assign n_sum  = is_vis_r ? n_hid : n_vis;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_query  = (in_cmd == CMD_QUERY_HID) || (in_cmd == CMD_QUERY_VIS);

  // Count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_count_r  <= 7'd64;
      hid_count_r  <= 7'd64;
      cond_count_r <= 5'd16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VIS_COUNT:  vis_count_r  <= cfg_wdata;
        CFG_HID_COUNT:  hid_count_r  <= cfg_wdata;
        CFG_COND_COUNT: cond_count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      drain_r  <= 1'b0;
      is_vis_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      drain_r  <= drain_nxt;
      is_vis_r <= is_vis_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && is_query) state_nxt = ST_BIAS;
      ST_BIAS:  state_nxt = ST_VHSUM;
      ST_VHSUM: if (cnt_r >= n_sum) state_nxt = is_vis_r ? ST_DRAIN : ST_CSUM;
      ST_CSUM:  if (cnt_r >= 7'(n_cond)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r) state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_EMIT;
      ST_EMIT:  if (dp_status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Counters and query kind
  always_comb begin
    cnt_nxt    = cnt_r;
    drain_nxt  = 1'b0;
    is_vis_nxt = is_vis_r;
    case (state_r)
      ST_IDLE:  if (accept && is_query) is_vis_nxt = (in_cmd == CMD_QUERY_VIS);
      ST_BIAS:  cnt_nxt = '0;
      ST_VHSUM: cnt_nxt = (cnt_r < n_sum) ? cnt_r + 7'd1 : 7'd0;
      ST_CSUM:  if (cnt_r < 7'(n_cond)) cnt_nxt = cnt_r + 7'd1;
      ST_DRAIN: drain_nxt = !drain_r;
      default: ;
    endcase
  end

  // Datapath commands
  always_comb begin
    dp_cmd           = '0;
    dp_cmd.src       = SRC_VBIAS;
    dp_cmd.idx       = cnt_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        dp_cmd.wr_en     = accept && !is_query;
        dp_cmd.load_item = accept && is_query;
      end
      ST_BIAS: begin
        dp_cmd.issue = 1'b1;
        dp_cmd.first = 1'b1;
        dp_cmd.src   = is_vis_r ? SRC_VBIAS : SRC_HBIAS;
      end
      ST_VHSUM: begin
        dp_cmd.issue = (cnt_r < n_sum);
        dp_cmd.src   = is_vis_r ? SRC_VH_ROW : SRC_VH_COL;
      end
      ST_CSUM: begin
        dp_cmd.issue = (cnt_r < 7'(n_cond));
        dp_cmd.src   = SRC_COND;
      end
      ST_SAT:  dp_cmd.sat_en = 1'b1;
      ST_EMIT: dp_cmd.emit   = dp_status.out_free;
      default: ;
    endcase
  end

  // A query blocks intake on the following cycle
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_query) |=> !in_tready)
    else $error("intake open right after a query");

  // Term walk never passes its count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VHSUM) |-> (cnt_r <= n_sum))
    else $error("visible/hidden term count overrun");

  // Bias term always opens the walk
  a_bias_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIAS) |=> (state_r == ST_VHSUM) && (cnt_r == 7'd0))
    else $error("bias step not followed by term walk");

endmodule
`default_nettype wire

// ===== hdl/rbmcu_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbmcu_dp: stores, MAC pipeline and probability output
// Weight, bias and node memories with registered reads, a 16x16 multiplier,
// a 40-bit accumulator, saturation, sigmoid lookup and the output register.
// ----------------------------------------------------------------------------
module rbmcu_dp
  import rbmcu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           dp_cmd,
  output dp_status_t             dp_status,
  input  wire logic [3:0]        in_cmd,
  input  wire logic [IDX_W-1:0]  in_row,
  input  wire logic [IDX_W-1:0]  in_col,
  input  wire logic signed [15:0] in_data,
  input  wire logic              in_bit,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_prob,
  output logic                   out_kind,
  output logic [IDX_W-1:0]       out_index
);

  localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

  // Memories
  logic signed [15:0] vh_mem [VIS_MAX*HID_MAX];
  logic signed [15:0] ch_mem [HID_MAX*COND_MAX];
  logic signed [15:0] vb_mem [VIS_MAX];
  logic signed [15:0] hb_mem [HID_MAX];
  logic signed [15:0] vn_mem [VIS_MAX];
  logic signed [15:0] hn_mem [HID_MAX];
  logic signed [15:0] cn_mem [COND_MAX];

  logic [IDX_W-1:0]         row_r;
  logic                     kind_r, bit_r;
  logic [2*IDX_W-1:0]       vh_ra;
  logic [IDX_W+COND_AW-1:0] ch_ra;
  logic signed [15:0]       vh_q, ch_q, vb_q, hb_q, vn_q, hn_q, cn_q;
  logic                     rd_vld_r, rd_first_r;
  src_t                     rd_src_r;
  logic signed [15:0]       op_a, op_b;
  logic signed [31:0]       prod_r;
  logic                     prod_vld_r, prod_first_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  s_full;
  logic signed [15:0]       s_sat;
  logic [15:0]              s_bias;
  logic [SIG_AW-1:0]        tbl_idx_r;
  logic [15:0]              p_tab;
  logic [16:0]              p_inv;
  logic [15:0]              p_sel;
  logic                     out_valid_r;
  logic [15:0]              out_prob_r;
  logic                     out_kind_r;
  logic [IDX_W-1:0]         out_index_r;
  logic                     cond_col_ok;

  // Query item capture
  always_ff @(posedge clk) begin
    if (dp_cmd.load_item) begin
      row_r  <= in_row;
      kind_r <= (in_cmd == CMD_QUERY_VIS);
      bit_r  <= in_bit;
    end
  end

  assign vh_ra = (dp_cmd.src == SRC_VH_ROW) ? {row_r, dp_cmd.idx} : {dp_cmd.idx, row_r};
  assign ch_ra = {row_r, dp_cmd.idx[COND_AW-1:0]};
  assign cond_col_ok = (in_col < IDX_W'(COND_MAX));

  // Weight memories
  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en && (in_cmd == CMD_VH_WEIGHT)) vh_mem[{in_row, in_col}] <= in_data;
    if (dp_cmd.issue) vh_q <= vh_mem[vh_ra];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en && (in_cmd == CMD_CH_WEIGHT) && cond_col_ok)
      ch_mem[{in_row, in_col[COND_AW-1:0]}] <= in_data;
    if (dp_cmd.issue) ch_q <= ch_mem[ch_ra];
  end

  // Bias memories
  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en && (in_cmd == CMD_VIS_BIAS)) vb_mem[in_row] <= in_data;
    if (dp_cmd.issue) vb_q <= vb_mem[row_r];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en && (in_cmd == CMD_HID_BIAS)) hb_mem[in_row] <= in_data;
    if (dp_cmd.issue) hb_q <= hb_mem[row_r];
  end

  // Node memories
  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en && (in_cmd == CMD_VIS_NODE)) vn_mem[in_row] <= in_data;
    if (dp_cmd.issue) vn_q <= vn_mem[dp_cmd.idx];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en && (in_cmd == CMD_HID_NODE)) hn_mem[in_row] <= in_data;
    if (dp_cmd.issue) hn_q <= hn_mem[dp_cmd.idx];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en && (in_cmd == CMD_COND_NODE) && (in_row < IDX_W'(COND_MAX)))
      cn_mem[in_row[COND_AW-1:0]] <= in_data;
    if (dp_cmd.issue) cn_q <= cn_mem[dp_cmd.idx[COND_AW-1:0]];
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= dp_cmd.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r   <= dp_cmd.first;
    rd_src_r     <= dp_cmd.src;
    prod_first_r <= rd_first_r;
  end

  // Operand select: bias terms multiply by 1.0
  always_comb begin
    case (rd_src_r)
      SRC_VBIAS:  begin op_a = vb_q; op_b = ONE_Q12; end
      SRC_HBIAS:  begin op_a = hb_q; op_b = ONE_Q12; end
      SRC_VH_ROW: begin op_a = vh_q; op_b = hn_q;    end
      SRC_VH_COL: begin op_a = vh_q; op_b = vn_q;    end
      SRC_COND:   begin op_a = ch_q; op_b = cn_q;    end
      default:    begin op_a = '0;   op_b = '0;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) prod_r <= op_a * op_b;
  end

  // Accumulator
  assign acc_nxt = prod_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (prod_vld_r) acc_r <= acc_nxt;
  end

  // Floor to Q4.12, saturate, table index
  assign s_full = acc_r >>> 12;
  always_comb begin
    if (s_full > ACC_W'(32767))       s_sat = 16'sh7FFF;
    else if (s_full < -ACC_W'(32768)) s_sat = -16'sh8000;
    else                              s_sat = s_full[15:0];
  end
  assign s_bias = {~s_sat[15], s_sat[14:0]};

  always_ff @(posedge clk) begin
    if (dp_cmd.sat_en) tbl_idx_r <= s_bias[15 -: SIG_AW];
  end

  // Probability for the asked value
  assign p_tab = SIG_TABLE[tbl_idx_r];
  assign p_inv = 17'h1_0000 - {1'b0, p_tab};
  assign p_sel = bit_r ? p_tab : (p_inv[16] ? 16'hFFFF : p_inv[15:0]);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      out_prob_r  <= p_sel;
      out_kind_r  <= kind_r;
      out_index_r <= row_r;
    end
  end

  assign dp_status.out_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_prob   = out_prob_r;
  assign out_kind   = out_kind_r;
  assign out_index  = out_index_r;

  // Result loaded only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending item");

  // Product stage follows a read stage
  a_prod_chain: assert property (@(posedge clk) disable iff (!rst_n)
    prod_vld_r |-> $past(rd_vld_r))
    else $error("product without operand read");

  // No writes into stores while a term is in flight
  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.issue |-> !dp_cmd.wr_en)
    else $error("store write during accumulation");

endmodule
`default_nettype wire

// ===== hdl/rbm_conditional_unit_probability_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_conditional_unit_probability_unit: conditional RBM unit probability
// Top level joining the sequencer and the MAC datapath.
// ----------------------------------------------------------------------------
// A hidden query walks its bias, vis_count weighted visible terms and cond_count
// conditional terms, a visible query its bias and hid_count weighted hidden terms
// (counts clamped to 64, 64 and 16), through the single multiply-accumulate unit
// that handles one term per cycle. Intake is closed while a query runs; a finished
// result waits in the output register while write items keep flowing. Store
// contents are undefined until written.
module rbm_conditional_unit_probability_unit
  import rbmcu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_wdata,
  // Input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // row_index[5:0], col_index[11:6],
                                      // data_value[27:12], query_bit[28], zero
  input  wire logic [3:0]  in_tuser,  // command[3:0]
  // Result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // probability[15:0], unit_index[21:16], zero
  output logic             out_tuser  // unit_kind[0]
);

  dp_cmd_t          dp_cmd;
  dp_status_t       dp_status;
  logic [15:0]      out_prob;
  logic [IDX_W-1:0] out_index;

  rbmcu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  rbmcu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .dp_status  (dp_status),
    .in_cmd     (in_tuser),
    .in_row     (in_tdata[5:0]),
    .in_col     (in_tdata[11:6]),
    .in_data    ($signed(in_tdata[27:12])),
    .in_bit     (in_tdata[28]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_prob   (out_prob),
    .out_kind   (out_tuser),
    .out_index  (out_index)
  );

  assign out_tdata = {2'b00, out_index, out_prob};

endmodule
`default_nettype wire

// ===== test/rbm_prob_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_prob_checker: predictor and result check for the unit probability block
// Tracks the register and store writes seen on the ports, computes the
// probability of every accepted query and compares each result item, field by
// field, with the oldest pending prediction.
// ----------------------------------------------------------------------------
module rbm_prob_checker
  import rbmcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  output int          errors,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [15:0] prob;
    logic        kind;
    logic [5:0]  unit;
  } unit_prob_t;

  unit_prob_t prob_queue[$];

  logic [15:0] sigmoid_lut [SIGMOID_ENTRIES];

  logic [6:0] n_vis, n_hid;
  logic [4:0] n_cond;
  logic signed [15:0] w_vh [VIS_MAX][HID_MAX];
  logic signed [15:0] w_ch [HID_MAX][COND_MAX];
  logic signed [15:0] b_vis [VIS_MAX];
  logic signed [15:0] b_hid [HID_MAX];
  logic signed [15:0] v_node [VIS_MAX];
  logic signed [15:0] h_node [HID_MAX];
  logic signed [15:0] c_node [COND_MAX];

  // Sigmoid at the midpoint of bin k, Q0.16, from a Q32 Taylor series
  function automatic logic [15:0] sigmoid_bin(int k);
    longint x, acc;
    longint unsigned mag, frac, whole, term, e, den, p;
    x = (longint'(2 * k + 1) * (64'sd8 <<< 32)) / SIGMOID_ENTRIES - (64'sd8 <<< 32);
    mag = (x < 0) ? longint'(-x) : x;
    whole = mag >> 32;
    frac = mag & 64'hFFFF_FFFF;
    term = 64'd1 << 32;
    acc = 64'sd1 <<< 32;
    for (int t = 1; t <= 15; t++) begin
      term = ((term * frac) >> 32) / longint'(t);
      if (t % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    e = (acc < 0) ? 64'd0 : acc;
    for (longint unsigned j = 0; j < whole; j++) begin
      e = (e * 64'd1580030169 + 64'h8000_0000) >> 32;
    end
    den = (64'd1 << 32) + e;
    if (x >= 0) p = ((64'd1 << 48) + (den >> 1)) / den;
    else p = ((e << 16) + (den >> 1)) / den;
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  // Q.24 sum to probability of the asked value
  function automatic logic [15:0] sum_to_prob(longint acc, logic bit_val);
    longint s;
    int unsigned p;
    s = acc >>> 12;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    p = sigmoid_lut[8'((s + 32768) >> 8)];
    if (!bit_val) p = 65536 - p;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  initial begin
    for (int k = 0; k < SIGMOID_ENTRIES; k++) sigmoid_lut[k] = sigmoid_bin(k);
  end

  // Configuration, store writes and query prediction
  always @(posedge clk) begin
    cmd_t cmd;
    logic [5:0] row, col;
    logic signed [15:0] val;
    logic qbit;
    longint acc;
    int nv, nh, nc;
    if (!rst_n) begin
      n_vis <= 7'd64;
      n_hid <= 7'd64;
      n_cond <= 5'd16;
      errors = 0;
      checked = 0;
      prob_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_VIS_COUNT: n_vis <= cfg_wdata;
          CFG_HID_COUNT: n_hid <= cfg_wdata;
          CFG_COND_COUNT: n_cond <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        cmd = cmd_t'(in_tuser);
        row = in_tdata[5:0];
        col = in_tdata[11:6];
        val = in_tdata[27:12];
        qbit = in_tdata[28];
        nv = (n_vis > VIS_MAX) ? VIS_MAX : n_vis;
        nh = (n_hid > HID_MAX) ? HID_MAX : n_hid;
        nc = (n_cond > COND_MAX) ? COND_MAX : n_cond;
        case (cmd)
          CMD_VH_WEIGHT: w_vh[row][col] = val;
          CMD_VIS_BIAS: b_vis[row] = val;
          CMD_HID_BIAS: b_hid[row] = val;
          CMD_CH_WEIGHT: if (col < COND_MAX) w_ch[row][col] = val;
          CMD_VIS_NODE: v_node[row] = val;
          CMD_HID_NODE: h_node[row] = val;
          CMD_COND_NODE: if (row < COND_MAX) c_node[row] = val;
          CMD_QUERY_HID: begin
            acc = longint'(b_hid[row]) * 4096;
            for (int i = 0; i < nv; i++) acc += longint'(w_vh[i][row]) * v_node[i];
            for (int i = 0; i < nc; i++) acc += longint'(w_ch[row][i]) * c_node[i];
            prob_queue.push_back('{sum_to_prob(acc, qbit), 1'b0, row});
          end
          CMD_QUERY_VIS: begin
            acc = longint'(b_vis[row]) * 4096;
            for (int i = 0; i < nh; i++) acc += longint'(w_vh[row][i]) * h_node[i];
            prob_queue.push_back('{sum_to_prob(acc, qbit), 1'b1, row});
          end
          default: ;
        endcase
      end
      // result compare
      if (out_tvalid && out_tready) begin
        unit_prob_t got, want;
        got = '{out_tdata[15:0], out_tuser, out_tdata[21:16]};
        if (prob_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item %h", $time, got);
        end else begin
          want = prob_queue.pop_front();
          checked++;
          if (got.prob !== want.prob || got.kind !== want.kind || got.unit !== want.unit) begin
            errors++;
            $display("%0t: mismatch expected prob=%0d kind=%0d unit=%0d, actual prob=%0d kind=%0d unit=%0d",
                     $time, want.prob, want.kind, want.unit, got.prob, got.kind, got.unit);
          end
        end
      end
    end
    pending = prob_queue.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the conditional RBM unit probability block
// Loads every store entry read by queries on units 0 and 63, runs directed extremes, then
// random writes and queries under several count settings with random stalls
// on both channels; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import rbmcu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_VIS_COUNT;
  logic [6:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  int errors, pending, checked;
  bit rx_hold = 0;     // request a long receiver stall
  bit no_gaps = 0;     // stretch without idling on either side
  int n_items = 0;

  logic [5:0] prep_units [2] = '{6'd0, 6'd63};

  always #2 clk = ~clk;

  rbm_conditional_unit_probability_unit DUT (.*);

  rbm_prob_checker prob_check (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Mostly small Q4.12 values so sums land inside the sigmoid range
  function automatic logic [15:0] pick_value();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  // Result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        rx_hold = 0;
      end else if (!no_gaps && $urandom_range(0, 99) < 3) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else begin
        out_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) < 70);
      end
    end
  end

  // One item on the input channel; starts and ends at a falling edge
  task automatic send_item(cmd_t cmd, logic [5:0] row, logic [5:0] col,
                           logic [15:0] val, logic qbit);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser <= cmd;
    in_tdata <= {3'b000, qbit, val, col, row};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_counts(logic [6:0] nv, logic [6:0] nh, logic [6:0] nc);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_VIS_COUNT;
    cfg_wdata <= nv;
    @(negedge clk);
    cfg_index <= CFG_HID_COUNT;
    cfg_wdata <= nh;
    @(negedge clk);
    cfg_index <= CFG_COND_COUNT;
    cfg_wdata <= nc;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random writes anywhere, unknown commands, queries only on the fully loaded units 0 and 63
  task automatic random_phase(int count);
    int r;
    logic [5:0] unit;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      unit = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      if (r < 45)
        send_item(cmd_t'($urandom_range(0, 6)), 6'($urandom), 6'($urandom), pick_value(),
                  1'($urandom));
      else if (r < 70)
        send_item(CMD_QUERY_HID, unit, 6'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 95)
        send_item(CMD_QUERY_VIS, unit, 6'($urandom), 16'($urandom), 1'($urandom));
      else
        send_item(cmd_t'($urandom_range(9, 15)), 6'($urandom), 6'($urandom), 16'($urandom),
                  1'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // load every entry read by queries on units 0 and 63
    for (int i = 0; i < VIS_MAX; i++)
      send_item(CMD_VIS_NODE, 6'(i), 6'd0, pick_value(), 1'b0);
    for (int i = 0; i < HID_MAX; i++)
      send_item(CMD_HID_NODE, 6'(i), 6'd0, pick_value(), 1'b0);
    for (int i = 0; i < COND_MAX; i++)
      send_item(CMD_COND_NODE, 6'(i), 6'd0, pick_value(), 1'b0);
    foreach (prep_units[u]) begin
      send_item(CMD_HID_BIAS, prep_units[u], 6'd0, pick_value(), 1'b0);
      send_item(CMD_VIS_BIAS, prep_units[u], 6'd0, pick_value(), 1'b0);
      for (int i = 0; i < VIS_MAX; i++)
        send_item(CMD_VH_WEIGHT, 6'(i), prep_units[u], pick_value(), 1'b0);
      for (int i = 0; i < HID_MAX; i++)
        send_item(CMD_VH_WEIGHT, prep_units[u], 6'(i), pick_value(), 1'b0);
      for (int i = 0; i < COND_MAX; i++)
        send_item(CMD_CH_WEIGHT, prep_units[u], 6'(i), pick_value(), 1'b0);
    end

    // directed: both query kinds and bits, field extremes, unknown commands
    send_item(CMD_QUERY_HID, 6'd0, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_QUERY_HID, 6'd63, 6'd63, 16'hFFFF, 1'b1);
    send_item(CMD_QUERY_VIS, 6'd0, 6'd63, 16'h0000, 1'b1);
    send_item(CMD_QUERY_VIS, 6'd63, 6'd0, 16'hFFFF, 1'b0);
    send_item(cmd_t'(4'd9), 6'd63, 6'd63, 16'hFFFF, 1'b1);
    send_item(cmd_t'(4'd15), 6'd63, 6'd63, 16'h8000, 1'b1);
    // writes beyond the conditional stores are dropped
    send_item(CMD_CH_WEIGHT, 6'd63, 6'd63, 16'h7FFF, 1'b0);
    send_item(CMD_COND_NODE, 6'd63, 6'd0, 16'h7FFF, 1'b0);
    // saturate the hidden sum high, then the visible sum low
    send_item(CMD_VIS_NODE, 6'd63, 6'd0, 16'h7FFF, 1'b0);
    send_item(CMD_VH_WEIGHT, 6'd63, 6'd63, 16'h7FFF, 1'b0);
    send_item(CMD_HID_BIAS, 6'd63, 6'd0, 16'h7FFF, 1'b0);
    send_item(CMD_QUERY_HID, 6'd63, 6'd0, 16'h0000, 1'b1);
    send_item(CMD_QUERY_HID, 6'd63, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_HID_NODE, 6'd63, 6'd0, 16'h8000, 1'b0);
    send_item(CMD_VIS_BIAS, 6'd63, 6'd0, 16'h8000, 1'b0);
    send_item(CMD_QUERY_VIS, 6'd63, 6'd0, 16'h0000, 1'b1);
    send_item(CMD_QUERY_VIS, 6'd63, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_VIS_NODE, 6'd63, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_HID_NODE, 6'd63, 6'd0, 16'h0001, 1'b0);

    // receiver holds off while queries keep coming
    rx_hold = 1;
    random_phase(30);
    // sender waits for every result
    wait_idle();
    no_gaps = 1;
    random_phase(25);
    no_gaps = 0;

    // count settings: smallest, above store size, random, full
    set_counts(7'd1, 7'd1, 7'd0);
    random_phase(35);
    set_counts(7'd127, 7'd127, 7'd31);
    random_phase(35);
    set_counts(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
               7'($urandom_range(0, 16)));
    random_phase(35);
    set_counts(7'd64, 7'd64, 7'd16);
    random_phase(35);

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (120) @(negedge clk);
    $display("covered %0d input items and %0d checked query results", n_items, checked);
    $display("count settings: minimum, over store size, random, full; both query kinds");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rbmcu_pkg.sv
hdl/rbmcu_ctrl.sv
hdl/rbmcu_dp.sv
hdl/rbm_conditional_unit_probability_unit.sv
test/rbm_prob_checker.sv
test/tb.sv
